[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each macro samples on clk and is disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/rbf_pkg.sv]
// ----------------------------------------------------------------------------
// rbf_pkg
// Types, constants and helpers shared by the ray/box face intersection core.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int COORD_W    = 32;              // Q16.16 coordinate width
  localparam int NUM_W      = COORD_W + 1;     // |bound - origin|
  localparam int PROD_W     = 2 * COORD_W;     // |dir| * num
  localparam int Q_W        = 41;              // clamped offset, up to 2^40
  localparam int SUM_W      = Q_W + 2;         // origin + signed offset
  localparam int DIV_QBITS  = 44;              // quotient bits produced
  localparam int DIV_STEP   = 4;               // quotient bits per stage
  localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;
  localparam int NUM_AXES   = 3;
  localparam int NUM_FACES  = 6;
  localparam int NUM_LANES  = 2 * NUM_FACES;   // two off-axis coords per face
  localparam int SEL_STAGES = 2 * NUM_FACES;   // multiply + compare per face
  localparam int Q_DEPTH    = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int FACE_W     = 3;

  localparam logic [Q_W-1:0] OFFSET_CLAMP = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Face codes
  localparam logic [FACE_W-1:0] FACE_MIN_X  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_MAX_X  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_MIN_Y  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_MAX_Y  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_MIN_Z  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_MAX_Z  = 3'd5;
  localparam logic [FACE_W-1:0] FACE_INSIDE = 3'd6;
  localparam logic [FACE_W-1:0] FACE_MISS   = 3'd7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] lo;
    logic [NUM_AXES-1:0][COORD_W-1:0] hi;
  } box_t;

  // Classified ray as handed from front to back
  typedef struct packed {
    logic                              enclosed;
    logic [NUM_AXES-1:0][COORD_W-1:0]  org;
    logic [NUM_AXES-1:0]               dneg;
    logic [NUM_FACES-1:0]              cand;
    logic [NUM_FACES-1:0][NUM_W-1:0]   num;
    logic [NUM_AXES-1:0][COORD_W-1:0]  den;
  } ray_t;

  // One divider pipeline stage
  typedef struct packed {
    logic                 ovf;
    logic [COORD_W-1:0]   den;
    logic [COORD_W-1:0]   rem;
    logic [DIV_QBITS-1:0] nlo;
    logic [DIV_QBITS-1:0] quo;
  } div_t;

  // Face selection stage
  typedef struct packed {
    ray_t                              ray;
    logic [NUM_LANES-1:0][COORD_W-1:0] lpt;
    logic [NUM_FACES-1:0]              ok;
    logic                              found;
    logic [NUM_W-1:0]                  bnum;
    logic [COORD_W-1:0]                bden;
    logic [FACE_W-1:0]                 bface;
    logic [NUM_AXES-1:0][COORD_W-1:0]  bpt;
    logic [PROD_W-1:0]                 p1;
    logic [PROD_W-1:0]                 p2;
  } sel_t;

  // Off-plane axis j (0 or 1) of a face on axis a
  function automatic int other_axis(int a, int j);
    int r;
    case (a)
      0:       r = (j == 0) ? 1 : 2;
      1:       r = (j == 0) ? 0 : 2;
      default: r = (j == 0) ? 0 : 1;
    endcase
    return r;
  endfunction

  function automatic logic [FACE_W-1:0] face_code(int f);
    logic [FACE_W-1:0] c;
    case (f)
      0:       c = FACE_MIN_X;
      1:       c = FACE_MAX_X;
      2:       c = FACE_MIN_Y;
      3:       c = FACE_MAX_Y;
      4:       c = FACE_MIN_Z;
      default: c = FACE_MAX_Z;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/rbf_front.sv]
// ----------------------------------------------------------------------------
// rbf_front
// Accepts rays and classifies them: inside test, face candidates, distances.
// ----------------------------------------------------------------------------
module rbf_front (
  input  rbf_pkg::box_t        box,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   origin_x,
  input  logic signed [31:0]   origin_y,
  input  logic signed [31:0]   origin_z,
  input  logic signed [31:0]   dir_x,
  input  logic signed [31:0]   dir_y,
  input  logic signed [31:0]   dir_z,
  input  logic                 q_full,
  output logic                 push,
  output rbf_pkg::ray_t        ray
);
  import rbf_pkg::*;

  logic [NUM_AXES-1:0][COORD_W-1:0] o;
  logic [NUM_AXES-1:0][COORD_W-1:0] d;
  logic [NUM_AXES-1:0]              in_axis;

  // Take a ray whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign o[0] = origin_x;
  assign o[1] = origin_y;
  assign o[2] = origin_z;
  assign d[0] = dir_x;
  assign d[1] = dir_y;
  assign d[2] = dir_z;

  // Classify per axis
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      in_axis[k] = ($signed(o[k]) >= $signed(box.lo[k])) &&
                   ($signed(o[k]) <= $signed(box.hi[k]));
      ray.org[k]  = o[k];
      ray.dneg[k] = d[k][COORD_W-1];
      ray.den[k]  = d[k][COORD_W-1] ? (~d[k] + COORD_W'(1)) : d[k];
      ray.num[2*k]   = {box.lo[k][COORD_W-1], box.lo[k]} - {o[k][COORD_W-1], o[k]};
      ray.num[2*k+1] = {o[k][COORD_W-1], o[k]} - {box.hi[k][COORD_W-1], box.hi[k]};
      ray.cand[2*k]   = ($signed(o[k]) <= $signed(box.lo[k])) &&
                        !d[k][COORD_W-1] && (d[k] != '0);
      ray.cand[2*k+1] = ($signed(o[k]) >= $signed(box.hi[k])) && d[k][COORD_W-1];
    end
    ray.enclosed = &in_axis;
  end

endmodule

[rtl/core/rbf_queue.sv]
// ----------------------------------------------------------------------------
// rbf_queue
// Short queue of classified rays between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rbf_pkg::ray_t wdata,
  input  logic          pop,
  output rbf_pkg::ray_t rdata,
  output logic          empty,
  output logic          full
);
  import rbf_pkg::*;

  ray_t               mem [Q_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(Q_DEPTH));
  assign rdata = mem[rptr];
  assign count_next = count + QCNT_W'(push) - QCNT_W'(pop);

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  `ASSERT_ALWAYS(a_count_range, count <= QCNT_W'(Q_DEPTH), "queue count beyond depth")
  `ASSERT_IMPLIES(a_no_overrun, full, !push, "push into full queue")
  `ASSERT_NEXT(a_pop_count, pop && !push, count == $past(count) - QCNT_W'(1), "pop miscount")

endmodule

[rtl/core/rbf_div.sv]
// ----------------------------------------------------------------------------
// rbf_div
// Pipelined restoring divider, four quotient bits per stage, result clamped.
// ----------------------------------------------------------------------------
module rbf_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rbf_pkg::PROD_W-1:0]   num,
  input  logic [rbf_pkg::COORD_W-1:0]  den,
  output logic [rbf_pkg::Q_W-1:0]      quo
);
  import rbf_pkg::*;

  div_t st [DIV_STAGES];
  div_t init;
  div_t last;

  // Quotient of 2^44 or more is flagged up front and clamped at the end
  always_comb begin
    init.den = den;
    init.rem = COORD_W'(num[PROD_W-1:DIV_QBITS]);
    init.ovf = init.rem >= den;
    init.nlo = num[DIV_QBITS-1:0];
    init.quo = '0;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_t cur;
    div_t nxt;

    if (s == 0) begin : g_first
      assign cur = init;
    end else begin : g_rest
      assign cur = st[s-1];
    end

    // Shift in one numerator bit per step, subtract when it fits
    always_comb begin
      logic [COORD_W:0]     sh;
      logic [COORD_W-1:0]   r;
      logic [DIV_QBITS-1:0] n;
      logic [DIV_QBITS-1:0] qq;
      r  = cur.rem;
      n  = cur.nlo;
      qq = cur.quo;
      for (int i = 0; i < DIV_STEP; i++) begin
        sh = {r, n[DIV_QBITS-1]};
        n  = {n[DIV_QBITS-2:0], 1'b0};
        if (sh >= {1'b0, cur.den}) begin
          sh = sh - {1'b0, cur.den};
          qq = {qq[DIV_QBITS-2:0], 1'b1};
        end else begin
          qq = {qq[DIV_QBITS-2:0], 1'b0};
        end
        r = sh[COORD_W-1:0];
      end
      nxt     = cur;
      nxt.rem = r;
      nxt.nlo = n;
      nxt.quo = qq;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= nxt;
      end
    end
  end

  // Clamp to 2^40
  assign last = st[DIV_STAGES-1];
  assign quo  = (last.ovf || (last.quo > DIV_QBITS'(OFFSET_CLAMP))) ?
                OFFSET_CLAMP : last.quo[Q_W-1:0];

endmodule

[rtl/core/rbf_back.sv]
// ----------------------------------------------------------------------------
// rbf_back
// Computes face hit points, checks them against the box, keeps the nearest.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbf_back (
  input  logic                clk,
  input  logic                rst,
  input  rbf_pkg::box_t       box,
  input  logic                q_empty,
  input  rbf_pkg::ray_t       q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic signed [31:0]  point_x,
  output logic signed [31:0]  point_y,
  output logic signed [31:0]  point_z,
  output logic [2:0]          face
);
  import rbf_pkg::*;

  logic                              adv;
  logic                              v0;
  ray_t                              ray0;
  logic [NUM_LANES-1:0][PROD_W-1:0]  prod0;
  logic [NUM_LANES-1:0][PROD_W-1:0]  prod_next;
  logic [NUM_LANES-1:0][Q_W-1:0]     qlane;
  logic [DIV_STAGES-1:0]             sv;
  ray_t                              sray [DIV_STAGES];
  ray_t                              pr;
  logic [NUM_LANES-1:0][COORD_W-1:0] lpt_c;
  logic [NUM_LANES-1:0]              inb_c;
  sel_t                              s0n;
  sel_t                              sel [SEL_STAGES+1];
  logic [SEL_STAGES:0]               selv;
  sel_t                              fin;

  // Whole back pipeline moves when the output register is free or taken
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  // Stage 0: off-axis products |dir_k| * num_f
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_mul
    localparam int F = l / 2;
    localparam int A = F / 2;
    localparam int K = other_axis(A, l % 2);
    assign prod_next[l] = PROD_W'(q_data.den[K]) * PROD_W'(q_data.num[F]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray0  <= q_data;
      prod0 <= prod_next;
    end
  end

  // Divider lanes, ray data travels alongside
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
    localparam int A = (l / 2) / 2;
    rbf_div u_div (
      .clk (clk),
      .en  (adv),
      .num (prod0[l]),
      .den (ray0.den[A]),
      .quo (qlane[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (adv) begin
      sv <= {sv[DIV_STAGES-2:0], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sray[0] <= ray0;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sray[i] <= sray[i-1];
      end
    end
  end

  assign pr = sray[DIV_STAGES-1];

  // Hit point per lane: signed offset, saturate, range check
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_pt
    localparam int F = l / 2;
    localparam int A = F / 2;
    localparam int K = other_axis(A, l % 2);
    logic [SUM_W-1:0] offs;
    logic [SUM_W-1:0] sum;
    logic             fits;

    assign offs  = pr.dneg[K] ? (~{2'b00, qlane[l]} + SUM_W'(1)) : {2'b00, qlane[l]};
    assign sum   = {{(SUM_W-COORD_W){pr.org[K][COORD_W-1]}}, pr.org[K]} + offs;
    assign fits  = (&sum[SUM_W-1:COORD_W-1]) || !(|sum[SUM_W-1:COORD_W-1]);
    assign lpt_c[l] = fits ? sum[COORD_W-1:0] :
                      (sum[SUM_W-1] ? COORD_MIN : COORD_MAX);
    assign inb_c[l] = ($signed(lpt_c[l]) >= $signed(box.lo[K])) &&
                      ($signed(lpt_c[l]) <= $signed(box.hi[K]));
  end

  // Seed the selection with no face found
  always_comb begin
    s0n.ray   = pr;
    s0n.lpt   = lpt_c;
    for (int f = 0; f < NUM_FACES; f++) begin
      s0n.ok[f] = inb_c[2*f] && inb_c[2*f+1];
    end
    s0n.found = 1'b0;
    s0n.bnum  = '0;
    s0n.bden  = COORD_W'(1);
    s0n.bface = FACE_MISS;
    s0n.bpt   = '0;
    s0n.p1    = '0;
    s0n.p2    = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel[0] <= s0n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selv <= '0;
    end else if (adv) begin
      selv <= {selv[SEL_STAGES-1:0], sv[DIV_STAGES-1]};
    end
  end

  // Faces in order: cross-multiply, then keep the strictly nearer one
  for (genvar f = 0; f < NUM_FACES; f++) begin : g_sel
    localparam int A  = f / 2;
    localparam int K0 = other_axis(A, 0);
    localparam int K1 = other_axis(A, 1);
    sel_t               a_nx;
    sel_t               b_nx;
    logic [COORD_W-1:0] bound;

    assign bound = ((f % 2) == 1) ? box.hi[A] : box.lo[A];

    always_comb begin
      a_nx    = sel[2*f];
      a_nx.p1 = PROD_W'(sel[2*f].ray.num[f]) * PROD_W'(sel[2*f].bden);
      a_nx.p2 = PROD_W'(sel[2*f].bnum) * PROD_W'(sel[2*f].ray.den[A]);
    end

    always_comb begin
      b_nx = sel[2*f+1];
      if (b_nx.ray.cand[f] && b_nx.ok[f] && (!b_nx.found || (b_nx.p1 < b_nx.p2))) begin
        b_nx.found   = 1'b1;
        b_nx.bnum    = b_nx.ray.num[f];
        b_nx.bden    = b_nx.ray.den[A];
        b_nx.bface   = face_code(f);
        b_nx.bpt[A]  = bound;
        b_nx.bpt[K0] = b_nx.lpt[2*f];
        b_nx.bpt[K1] = b_nx.lpt[2*f+1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sel[2*f+1] <= a_nx;
        sel[2*f+2] <= b_nx;
      end
    end
  end

  assign fin = sel[SEL_STAGES];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= selv[SEL_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.ray.enclosed) begin
        hit     <= 1'b1;
        point_x <= fin.ray.org[0];
        point_y <= fin.ray.org[1];
        point_z <= fin.ray.org[2];
        face    <= FACE_INSIDE;
      end else if (fin.found) begin
        hit     <= 1'b1;
        point_x <= fin.bpt[0];
        point_y <= fin.bpt[1];
        point_z <= fin.bpt[2];
        face    <= fin.bface;
      end else begin
        hit     <= 1'b0;
        point_x <= '0;
        point_y <= '0;
        point_z <= '0;
        face    <= FACE_MISS;
      end
    end
  end

  `ASSERT_IMPLIES(a_hit_face, out_valid && hit, face != FACE_MISS, "hit with miss code")
  `ASSERT_IMPLIES(a_miss_zero, out_valid && !hit, (face == FACE_MISS) && (point_x == '0) && (point_y == '0) && (point_z == '0), "miss not zeroed")

endmodule

[rtl/core/ray_box_face_intersection_core.sv]
// ----------------------------------------------------------------------------
// ray_box_face_intersection_core
// Ray against a configured axis-aligned box, Q16.16, one ray per cycle while the queue has room.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    origin_x/y/z, dir_x/y/z
//   out       out_valid / out_ready  hit, point_x/y/z, face
//   cfg       cfg_we                 cfg_index, cfg_data
//
// One ray is accepted per cycle while the queue has room; a result leaves
// once its ray has passed the queue and the back pipeline.
// The depth is set by the twelve pipelined divider lanes (four quotient bits
// per stage, eleven stages) and the six-face nearest-hit chain.
// Reset clears the box to the full range and empties the pipeline.
// An output stall freezes the back pipeline; the four-entry queue keeps
// in_ready high until it fills.
// ----------------------------------------------------------------------------
module ray_box_face_intersection_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  origin_x,
  input  logic signed [31:0]  origin_y,
  input  logic signed [31:0]  origin_z,
  input  logic signed [31:0]  dir_x,
  input  logic signed [31:0]  dir_y,
  input  logic signed [31:0]  dir_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic signed [31:0]  point_x,
  output logic signed [31:0]  point_y,
  output logic signed [31:0]  point_z,
  output logic [2:0]          face
);
  import rbf_pkg::*;

  box_t box;
  ray_t f_ray;
  ray_t q_ray;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  // Box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box.lo <= {NUM_AXES{COORD_MIN}};
      box.hi <= {NUM_AXES{COORD_MAX}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_MIN_X: box.lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box.lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box.lo[2] <= cfg_data;
        REG_BOX_MAX_X: box.hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box.hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box.hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rbf_front u_front (
    .box      (box),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .q_full   (q_full),
    .push     (push),
    .ray      (f_ray)
  );

  rbf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_ray),
    .pop   (pop),
    .rdata (q_ray),
    .empty (q_empty),
    .full  (q_full)
  );

  rbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .box       (box),
    .q_empty   (q_empty),
    .q_data    (q_ray),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .face      (face)
  );

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Ray/box face intersection testbench: drives rays through the valid/ready
// input, predicts each result with an exact integer model of the face tests
// and compares every output transfer field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rbf_pkg::*;

  typedef struct packed {
    logic [31:0] ox, oy, oz, dx, dy, dz;
  } ray_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] px, py, pz;
    logic [2:0]  face;
  } isect_t;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  // Box bounds as seen by the predictor
  longint box_lo[3];
  longint box_hi[3];

  function automatic logic [63:0] absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit within_box(int k, longint v);
    return v >= box_lo[k] && v <= box_hi[k];
  endfunction

  // Nearest face hit of one ray against the current box
  function automatic isect_t intersect_ray(ray_in_t r);
    longint o[3], d[3], pt[3], bpt[3], bound, off;
    logic [63:0] num, den, bnum, bden, q;
    bit found, ok, upper;
    int a, bface;
    isect_t res;
    o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
    d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
    found = 0; bface = FACE_MISS; bnum = 0; bden = 1;
    for (int k = 0; k < 3; k++) bpt[k] = 0;
    if (within_box(0, o[0]) && within_box(1, o[1]) && within_box(2, o[2])) begin
      res.hit = 1; res.px = r.ox; res.py = r.oy; res.pz = r.oz;
      res.face = FACE_INSIDE;
      return res;
    end
    for (int f = 0; f < 6; f++) begin
      a = f >> 1;
      upper = f[0];
      bound = upper ? box_hi[a] : box_lo[a];
      if (!upper && !(o[a] <= bound && d[a] > 0)) continue;
      if (upper && !(o[a] >= bound && d[a] < 0)) continue;
      num = absval(bound - o[a]);
      den = absval(d[a]);
      ok = 1;
      for (int k = 0; k < 3; k++) begin
        if (k == a) begin
          pt[k] = bound;
        end else begin
          q = (absval(d[k]) * num) / den;
          if (q > (64'd1 << 40)) q = 64'd1 << 40;
          off = (d[k] < 0) ? -longint'(q) : longint'(q);
          pt[k] = o[k] + off;
          if (pt[k] > CMAX) pt[k] = CMAX;
          if (pt[k] < CMIN) pt[k] = CMIN;
          if (!within_box(k, pt[k])) ok = 0;
        end
      end
      if (!ok) continue;
      if (!found || num * bden < bnum * den) begin
        found = 1; bnum = num; bden = den; bface = f;
        for (int k = 0; k < 3; k++) bpt[k] = pt[k];
      end
    end
    res.hit = found;
    res.px = bpt[0][31:0]; res.py = bpt[1][31:0]; res.pz = bpt[2][31:0];
    res.face = bface[2:0];
    return res;
  endfunction

  class isect_scoreboard;
    isect_t pending[$];
    int errors;

    function void note_ray(ray_in_t r);
      pending.push_back(intersect_ray(r));
    endfunction

    function void check_result(isect_t got);
      isect_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) begin
        $display("%0t: hit exp %0b got %0b", $time, exp.hit, got.hit); errors++;
      end
      if (got.px !== exp.px) begin
        $display("%0t: point_x exp %h got %h", $time, exp.px, got.px); errors++;
      end
      if (got.py !== exp.py) begin
        $display("%0t: point_y exp %h got %h", $time, exp.py, got.py); errors++;
      end
      if (got.pz !== exp.pz) begin
        $display("%0t: point_z exp %h got %h", $time, exp.pz, got.pz); errors++;
      end
      if (got.face !== exp.face) begin
        $display("%0t: face exp %0d got %0d", $time, exp.face, got.face); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic out_valid, out_ready = 0, hit;
  logic signed [31:0] point_x, point_y, point_z;
  logic [2:0] face;

  isect_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  ray_box_face_intersection_core u_top (.*);

  // Sample output transfers; stall the receiver at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{hit, point_x, point_y, point_z, face});
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one ray, holding it until transfer; valid stays up back to back unless a random idle gap is drawn
  task automatic send_ray(ray_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_ray(r);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx < 3) box_lo[idx] = $signed(val);
    else if (idx < 6) box_hi[idx - 3] = $signed(val);
    @(negedge clk);
  endtask

  // Drop valid and wait until all expected results are back
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_box(longint lx, longint ly, longint lz,
                         longint hx, longint hy, longint hz);
    write_reg(REG_BOX_MIN_X, lx[31:0]); write_reg(REG_BOX_MIN_Y, ly[31:0]);
    write_reg(REG_BOX_MIN_Z, lz[31:0]); write_reg(REG_BOX_MAX_X, hx[31:0]);
    write_reg(REG_BOX_MAX_Y, hy[31:0]); write_reg(REG_BOX_MAX_Z, hz[31:0]);
  endtask

  // Coordinate biased toward the box, its bounds and the extremes
  function automatic logic [31:0] rand_coord(int k);
    case ($urandom_range(5))
      0: return $urandom();
      1: return box_lo[k][31:0] + $urandom_range(4) - 2;
      2: return box_hi[k][31:0] + $urandom_range(4) - 2;
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(32'h00200000)) - 32'sh00100000;
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom();
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(32'h00040000)) - 32'sh00020000;
    endcase
  endfunction

  function automatic ray_in_t rand_ray();
    ray_in_t r;
    r.ox = rand_coord(0); r.oy = rand_coord(1); r.oz = rand_coord(2);
    r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
    // Aim most rays at a point inside the box
    if ($urandom_range(99) < 60) begin
      r.dx = 32'(((box_lo[0] + box_hi[0]) / 2 - $signed(r.ox)) >>> $urandom_range(4));
      r.dy = 32'(((box_lo[1] + box_hi[1]) / 2 - $signed(r.oy)) >>> $urandom_range(4));
      r.dz = 32'(((box_lo[2] + box_hi[2]) / 2 - $signed(r.oz)) >>> $urandom_range(4));
    end
    return r;
  endfunction

  task automatic random_rays(int n);
    repeat (n) send_ray(rand_ray());
  endtask

  localparam logic [31:0] ONE = 32'h00010000;

  initial begin
    ray_in_t r;
    for (int k = 0; k < 3; k++) begin
      box_lo[k] = CMIN; box_hi[k] = CMAX;
    end
    send_idle_pct = 35; recv_idle_pct = 48;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Reset box: everything is inside
    send_ray('{32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0});
    send_ray('{32'hffffffff, 32'h00000001, 32'h12345678, 0, 0, 0});
    drain();

    // Unit box: each face, edges, corner, misses, zero direction
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_ray('{-2*ONE, 0, 0, ONE, 0, 0});
    send_ray('{2*ONE, 0, 0, -ONE, 0, 0});
    send_ray('{0, -2*ONE, 0, 0, ONE, 0});
    send_ray('{0, 2*ONE, 0, 0, -ONE, 0});
    send_ray('{0, 0, -2*ONE, 0, 0, ONE});
    send_ray('{0, 0, 2*ONE, 0, 0, -ONE});
    send_ray('{-2*ONE, -2*ONE, -2*ONE, ONE, ONE, ONE});   // corner tie
    send_ray('{-2*ONE, 0, 0, -ONE, 0, 0});                // pointing away
    send_ray('{-2*ONE, 3*ONE, 0, ONE, 0, 0});             // passes by
    send_ray('{-2*ONE, 0, 0, 0, 0, 0});                   // zero direction
    send_ray('{ONE, ONE, ONE, 0, 0, 0});                  // on bound, inside
    send_ray('{-2*ONE, 0, 0, 1, 32'h7fffffff, 0});        // saturated point
    send_ray('{32'h80000000, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    send_ray('{32'h7fffffff, 0, 0, 32'h80000000, 1, 32'hffffffff});
    send_ray('{-2*ONE, 0, 0, ONE, 3, -5});
    drain();

    // Random phases over several boxes, extremes among them
    random_rays(70);
    drain();
    set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);             // inverted bounds
    send_ray('{0, 0, 0, ONE, ONE, ONE});
    random_rays(40);
    drain();
    write_reg(3'd6, 32'h0); write_reg(3'd7, 32'hffffffff);   // ignored indexes
    set_box(32'h80000000, -3*ONE, 32'h00001234, 5*ONE, 32'h7fffffff, 32'h00400000);
    send_idle_pct = 48; recv_idle_pct = 35;
    random_rays(100);
    drain();
    set_box($signed($urandom()) >>> 2, -ONE * 7, 0, 32'h30000000, 0, 32'h7fffffff);
    random_rays(50);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_box(-(ONE / 2), -(ONE / 2), -(ONE / 2), ONE / 2, ONE / 2, ONE / 2);
    random_rays(100);
    drain();
    set_box(0, 0, 0, 0, 0, 0);                            // degenerate point box
    random_rays(40);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rbf_pkg.sv
rtl/core/rbf_front.sv
rtl/core/rbf_queue.sv
rtl/core/rbf_div.sv
rtl/core/rbf_back.sv
rtl/core/ray_box_face_intersection_core.sv
tb/sv/tb.sv
